@@ rtl/icmp_echo_ping_engine_defines.svh @@
// Assertion macros shared by the ping engine modules
`ifndef ICMP_ECHO_PING_ENGINE_DEFINES_SVH
`define ICMP_ECHO_PING_ENGINE_DEFINES_SVH
// Check that a condition implies a consequence in the same cycle
`define IEP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Check that a condition implies a consequence in the next cycle
`define IEP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ rtl/iep_pkg.sv @@
// ----------------------------------------------------------------------------
// iep_pkg: shared types and constants
// Word structs, command codes and frame constants for the ping engine.
// ----------------------------------------------------------------------------
package iep_pkg;
    localparam int PAYLOAD_BYTES = 32;
    localparam int RX_FRAME_MAX  = 1518;
    localparam int FRAME_LEN     = 42 + PAYLOAD_BYTES;
    localparam int FRAME_WORDS   = (FRAME_LEN + 1) / 2;
    localparam int WIDX_W        = $clog2(FRAME_WORDS + 1);
    localparam int RXI_W         = 11;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_RX    = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [1:0] KIND_TX      = 2'd0;
    localparam logic [1:0] KIND_MATCH   = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;

    localparam logic [2:0] REG_OWN_MAC   = 3'd0;
    localparam logic [2:0] REG_OWN_IP    = 3'd1;
    localparam logic [2:0] REG_PEER_MAC  = 3'd2;
    localparam logic [2:0] REG_PEER_IP   = 3'd3;
    localparam logic [2:0] REG_IDENT     = 3'd4;
    localparam logic [2:0] REG_SEQ       = 3'd5;
    localparam logic [2:0] REG_SPINS     = 3'd6;
    localparam logic [2:0] REG_TRY_LIMIT = 3'd7;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] rx_data;
        logic       rx_end;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] tx_word;
        logic        tx_end;
    } out_word_t;

    // Command from front to back: send frame, or emit a status word
    typedef struct packed {
        logic       send;
        logic [1:0] kind;
    } cmd_t;

    typedef struct packed {
        logic [47:0] own_mac;
        logic [31:0] own_ip;
        logic [47:0] peer_mac;
        logic [31:0] peer_ip;
        logic [15:0] ident;
        logic [15:0] seq;
    } frame_cfg_t;

    typedef enum logic [0:0] {
        BK_IDLE,
        BK_SEND
    } bk_state_t;

    // Payload index stays below PAYLOAD_BYTES (32); two compare-subtract steps reduce any index below 78 mod 26
    function automatic logic [7:0] pay_byte(input int i);
        int r;
        r = i;
        if (r >= 52)
            r = r - 52;
        else if (r >= 26)
            r = r - 26;
        return 8'(65 + r);
    endfunction

    // Constant sum of the ICMP payload words
    function automatic logic [31:0] pay_sum();
        logic [31:0] s;
        int i;
        s = 32'd0;
        for (i = 0; i + 1 < PAYLOAD_BYTES; i += 2)
            s = s + {16'd0, pay_byte(i), pay_byte(i + 1)};
        if ((PAYLOAD_BYTES % 2) != 0)
            s = s + {16'd0, pay_byte(PAYLOAD_BYTES - 1), 8'd0};
        return s;
    endfunction

    function automatic logic [15:0] fold_not(input logic [19:0] s);
        logic [16:0] a;
        logic [15:0] b;
        a = {1'b0, s[15:0]} + {13'd0, s[19:16]};
        b = a[15:0] + {15'd0, a[16]};
        return ~b;
    endfunction
endpackage

@@ rtl/iep_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// iep_cmd_fifo: command queue between front and back
// Four-entry queue of commands; lets the front keep taking words.
// ----------------------------------------------------------------------------
module iep_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  iep_pkg::cmd_t wdata,
    output logic          full,
    input  logic          rd,
    output iep_pkg::cmd_t rdata,
    output logic          empty
);
    import iep_pkg::*;
    `include "icmp_echo_ping_engine_defines.svh"

    cmd_t       mem [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;

    assign full  = (cnt_reg == 3'd4);
    assign empty = (cnt_reg == 3'd0);
    assign rdata = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr && !full)
            mem[wp_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr && !full)
                wp_reg <= wp_reg + 2'd1;
            if (rd && !empty)
                rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'd0, wr && !full} - {2'd0, rd && !empty};
        end
    end

    `IEP_ASSERT_IMP(a_cnt_range, 1'b1, cnt_reg <= 3'd4)
    `IEP_ASSERT_NEXT(a_fill, (wr && !full && !(rd && !empty)), !empty)
    `IEP_ASSERT_NEXT(a_drain, (cnt_reg == 3'd1 && rd && !wr), empty)
endmodule

@@ rtl/iep_front.sv @@
// ----------------------------------------------------------------------------
// iep_front: classifier, receive matcher and retry timer
// Takes one input word a cycle and queues send or status commands.
// ----------------------------------------------------------------------------
module iep_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  iep_pkg::in_word_t in_word,
    input  logic [31:0]       peer_ip,
    input  logic [15:0]       ident,
    input  logic [15:0]       seq,
    input  logic [31:0]       spins_per_try,
    input  logic [7:0]        try_limit,
    output logic              cmd_push,
    output iep_pkg::cmd_t     cmd_word
);
    import iep_pkg::*;
    `include "icmp_echo_ping_engine_defines.svh"

    logic             active_reg, active_next;
    logic [7:0]       tries_reg, tries_next;
    logic [31:0]      spin_reg, spin_next;
    logic [RXI_W-1:0] rxi_reg, rxi_next;
    logic             rxok_reg, rxok_next;
    logic             chk;
    logic [7:0]       want;
    logic [31:0]      period;
    logic [7:0]       limit;
    logic [RXI_W-1:0] rxi_inc;

    always_comb
    begin
        chk  = 1'b0;
        want = 8'd0;
        case (rxi_reg)
            11'd12: begin chk = 1'b1; want = 8'h08; end
            11'd13: begin chk = 1'b1; want = 8'h00; end
            11'd23: begin chk = 1'b1; want = 8'd1; end
            11'd26: begin chk = 1'b1; want = peer_ip[31:24]; end
            11'd27: begin chk = 1'b1; want = peer_ip[23:16]; end
            11'd28: begin chk = 1'b1; want = peer_ip[15:8]; end
            11'd29: begin chk = 1'b1; want = peer_ip[7:0]; end
            11'd34: begin chk = 1'b1; want = 8'd0; end
            11'd38: begin chk = 1'b1; want = ident[15:8]; end
            11'd39: begin chk = 1'b1; want = ident[7:0]; end
            11'd40: begin chk = 1'b1; want = seq[15:8]; end
            11'd41: begin chk = 1'b1; want = seq[7:0]; end
            default:
            begin
                if (rxi_reg >= 11'd42 && rxi_reg < 11'(FRAME_LEN))
                begin
                    chk  = 1'b1;
                    want = pay_byte(int'(rxi_reg) - 42);
                end
            end
        endcase
    end

    assign period  = (spins_per_try == 32'd0) ? 32'd1 : spins_per_try;
    assign limit   = (try_limit == 8'd0) ? 8'd1 : try_limit;
    assign rxi_inc = (rxi_reg < 11'(RX_FRAME_MAX)) ? rxi_reg + 11'd1 : rxi_reg;

    always_comb
    begin
        active_next = active_reg;
        tries_next  = tries_reg;
        spin_next   = spin_reg;
        rxi_next    = rxi_reg;
        rxok_next   = rxok_reg;
        cmd_push    = 1'b0;
        cmd_word    = '{send: 1'b0, kind: KIND_TX};
        if (in_valid)
        begin
            case (in_word.op)
                OP_START:
                begin
                    active_next = 1'b1;
                    tries_next  = 8'd1;
                    spin_next   = '0;
                    rxi_next    = '0;
                    rxok_next   = 1'b1;
                    cmd_push    = 1'b1;
                    cmd_word    = '{send: 1'b1, kind: KIND_TX};
                end
                OP_RX:
                begin
                    if (rxi_reg < 11'(RX_FRAME_MAX) && chk && want != in_word.rx_data)
                        rxok_next = 1'b0;
                    rxi_next = rxi_inc;
                    if (in_word.rx_end)
                    begin
                        if (active_reg && rxok_next && rxi_inc >= 11'(FRAME_LEN))
                        begin
                            active_next = 1'b0;
                            cmd_push    = 1'b1;
                            cmd_word    = '{send: 1'b0, kind: KIND_MATCH};
                        end
                        rxi_next  = '0;
                        rxok_next = 1'b1;
                    end
                end
                OP_TICK:
                begin
                    if (active_reg)
                    begin
                        // compare count+1 >= period without a wide adder chain
                        if (spin_reg >= period - 32'd1)
                        begin
                            spin_next = '0;
                            cmd_push  = 1'b1;
                            if (tries_reg >= limit)
                            begin
                                active_next = 1'b0;
                                cmd_word    = '{send: 1'b0, kind: KIND_TIMEOUT};
                            end
                            else
                            begin
                                tries_next = tries_reg + 8'd1;
                                cmd_word   = '{send: 1'b1, kind: KIND_TX};
                            end
                        end
                        else
                            spin_next = spin_reg + 32'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            tries_reg  <= '0;
            spin_reg   <= '0;
            rxi_reg    <= '0;
            rxok_reg   <= 1'b1;
        end
        else
        begin
            active_reg <= active_next;
            tries_reg  <= tries_next;
            spin_reg   <= spin_next;
            rxi_reg    <= rxi_next;
            rxok_reg   <= rxok_next;
        end
    end

    `IEP_ASSERT_IMP(a_rxi_sat, 1'b1, rxi_reg <= 11'(RX_FRAME_MAX))
    `IEP_ASSERT_IMP(a_push_valid, cmd_push, in_valid)
    `IEP_ASSERT_NEXT(a_start_active, (in_valid && in_word.op == OP_START), active_reg)
endmodule

@@ rtl/iep_back.sv @@
// ----------------------------------------------------------------------------
// iep_back: frame generator
// Pops commands, builds checksums and streams frame or status words out.
// ----------------------------------------------------------------------------
module iep_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_empty,
    input  iep_pkg::cmd_t       cmd_word,
    output logic                cmd_pop,
    input  iep_pkg::frame_cfg_t fcfg,
    output logic                out_valid,
    output iep_pkg::out_word_t  out_word,
    input  logic                out_take
);
    import iep_pkg::*;
    `include "icmp_echo_ping_engine_defines.svh"

    bk_state_t         st_reg, st_next;
    logic [WIDX_W-1:0] w_reg, w_next;
    logic [15:0]       ipc_reg, ipc_next, icc_reg, icc_next;
    logic              ov_reg, ov_next;
    out_word_t         ow_reg, ow_next;
    logic [19:0]       ip_sum, ic_sum;
    logic [15:0]       word;
    logic              slot_free;

    localparam logic [31:0] PSUM = pay_sum();

    assign ip_sum = 20'h4500 + 20'(28 + PAYLOAD_BYTES) + 20'h0001 + 20'h4001
                  + {4'd0, fcfg.own_ip[31:16]} + {4'd0, fcfg.own_ip[15:0]}
                  + {4'd0, fcfg.peer_ip[31:16]} + {4'd0, fcfg.peer_ip[15:0]};
    assign ic_sum = 20'h0800 + {4'd0, fcfg.ident} + {4'd0, fcfg.seq} + PSUM[19:0];

    function automatic logic [7:0] tbyte(input int p, input logic [15:0] ipc,
                                         input logic [15:0] icc, input frame_cfg_t c);
        logic [7:0] b;
        b = 8'd0;
        if (p < 6)
            b = c.peer_mac[8*(5-p) +: 8];
        else if (p < 12)
            b = c.own_mac[8*(11-p) +: 8];
        else if (p == 12) b = 8'h08;
        else if (p == 14) b = 8'h45;
        else if (p == 16) b = 8'((28 + PAYLOAD_BYTES) >> 8);
        else if (p == 17) b = 8'(28 + PAYLOAD_BYTES);
        else if (p == 19) b = 8'd1;
        else if (p == 22) b = 8'd64;
        else if (p == 23) b = 8'd1;
        else if (p == 24) b = ipc[15:8];
        else if (p == 25) b = ipc[7:0];
        else if (p >= 26 && p < 30) b = c.own_ip[8*(29-p) +: 8];
        else if (p >= 30 && p < 34) b = c.peer_ip[8*(33-p) +: 8];
        else if (p == 34) b = 8'd8;
        else if (p == 36) b = icc[15:8];
        else if (p == 37) b = icc[7:0];
        else if (p == 38) b = c.ident[15:8];
        else if (p == 39) b = c.ident[7:0];
        else if (p == 40) b = c.seq[15:8];
        else if (p == 41) b = c.seq[7:0];
        else if (p >= 42 && p < FRAME_LEN) b = pay_byte(p - 42);
        return b;
    endfunction

    assign word = {tbyte(2 * int'(w_reg), ipc_reg, icc_reg, fcfg),
                   tbyte(2 * int'(w_reg) + 1, ipc_reg, icc_reg, fcfg)};
    assign slot_free = !ov_reg || out_take;

    always_comb
    begin
        st_next  = st_reg;
        w_next   = w_reg;
        ipc_next = ipc_reg;
        icc_next = icc_reg;
        ov_next  = ov_reg && !out_take;
        ow_next  = ow_reg;
        cmd_pop  = 1'b0;
        case (st_reg)
            BK_IDLE:
            begin
                if (!cmd_empty && slot_free)
                begin
                    cmd_pop = 1'b1;
                    if (cmd_word.send)
                    begin
                        // latch checksums; words are produced in BK_SEND once the output slot is free
                        ipc_next = fold_not(ip_sum);
                        icc_next = fold_not(ic_sum);
                        w_next   = '0;
                        st_next  = BK_SEND;
                    end
                    else
                    begin
                        ov_next = 1'b1;
                        ow_next = '{kind: cmd_word.kind, tx_word: 16'd0, tx_end: 1'b0};
                    end
                end
            end
            BK_SEND:
            begin
                if (slot_free)
                begin
                    ov_next = 1'b1;
                    ow_next = '{kind: KIND_TX, tx_word: word,
                                tx_end: (w_reg == WIDX_W'(FRAME_WORDS - 1))};
                    w_next  = w_reg + WIDX_W'(1);
                    if (w_reg == WIDX_W'(FRAME_WORDS - 1))
                        st_next = BK_IDLE;
                end
            end
            default: st_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= BK_IDLE;
            w_reg  <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            w_reg  <= w_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ipc_reg <= ipc_next;
        icc_reg <= icc_next;
        ow_reg  <= ow_next;
    end

    assign out_valid = ov_reg;
    assign out_word  = ow_reg;

    `IEP_ASSERT_NEXT(a_hold, (ov_reg && !out_take), ov_reg && $stable(ow_reg))
    `IEP_ASSERT_IMP(a_pop_idle, cmd_pop, st_reg == BK_IDLE)
    `IEP_ASSERT_IMP(a_wrange, st_reg == BK_SEND, w_reg < WIDX_W'(FRAME_WORDS))
endmodule

@@ rtl/icmp_echo_ping_engine.sv @@
// ICMP echo engine: push command words (start, received byte, poll tick) and pop result
// words (frame words, reply matched, timed out). The front takes one input word every
// cycle while the command queue has room; received bytes are matched in that same cycle.
// A start or resend queues a frame; the back part latches the two checksums, then
// streams (42+PAYLOAD_BYTES+1)/2 words, one per cycle while pop keeps up. full rises
// when the four-deep command queue fills. Configuration writes are always accepted.
// ----------------------------------------------------------------------------
// icmp_echo_ping_engine: top level
// Register file, front classifier, command queue and frame generator.
// ----------------------------------------------------------------------------
module icmp_echo_ping_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  iep_pkg::in_word_t  in_word,
    output logic               full,
    output logic               empty,
    input  logic               pop,
    output iep_pkg::out_word_t out_word,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data
);
    import iep_pkg::*;

    logic [47:0] own_mac_reg, peer_mac_reg;
    logic [31:0] own_ip_reg, peer_ip_reg, spins_reg;
    logic [15:0] ident_reg, seq_reg;
    logic [7:0]  limit_reg;
    logic        in_valid, q_push, q_full, q_empty, q_pop, out_valid;
    cmd_t        q_wdata, q_rdata;
    frame_cfg_t  fcfg;

    // Register writes are always accepted
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_mac_reg  <= '0;
            own_ip_reg   <= 32'd167772687;
            peer_mac_reg <= '0;
            peer_ip_reg  <= '0;
            ident_reg    <= '0;
            seq_reg      <= '0;
            spins_reg    <= 32'd2000000;
            limit_reg    <= 8'd20;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_OWN_MAC:   own_mac_reg  <= cfg_data[47:0];
                REG_OWN_IP:    own_ip_reg   <= cfg_data[31:0];
                REG_PEER_MAC:  peer_mac_reg <= cfg_data[47:0];
                REG_PEER_IP:   peer_ip_reg  <= cfg_data[31:0];
                REG_IDENT:     ident_reg    <= cfg_data[15:0];
                REG_SEQ:       seq_reg      <= cfg_data[15:0];
                REG_SPINS:     spins_reg    <= cfg_data[31:0];
                REG_TRY_LIMIT: limit_reg    <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign fcfg = '{own_mac: own_mac_reg, own_ip: own_ip_reg, peer_mac: peer_mac_reg,
                    peer_ip: peer_ip_reg, ident: ident_reg, seq: seq_reg};

    // Accept a word only while the queue has room for whatever it might queue
    assign full     = q_full;
    assign in_valid = push && !q_full;

    iep_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_word(in_word),
        .peer_ip(peer_ip_reg), .ident(ident_reg), .seq(seq_reg),
        .spins_per_try(spins_reg), .try_limit(limit_reg),
        .cmd_push(q_push), .cmd_word(q_wdata)
    );

    iep_cmd_fifo u_fifo (
        .clk(clk), .rst_n(rst_n), .wr(q_push), .wdata(q_wdata), .full(q_full),
        .rd(q_pop), .rdata(q_rdata), .empty(q_empty)
    );

    iep_back u_back (
        .clk(clk), .rst_n(rst_n), .cmd_empty(q_empty), .cmd_word(q_rdata),
        .cmd_pop(q_pop), .fcfg(fcfg), .out_valid(out_valid), .out_word(out_word),
        .out_take(pop)
    );

    assign empty = !out_valid;
endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: ICMP echo ping engine
// Drives start, received-byte and tick words through the push interface and
// checks every popped result word against a cycle-free predictor of the
// engine: request frames with both checksums, reply matching and timeouts.
// ----------------------------------------------------------------------------
module testbench;
    import iep_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    // Frame generation plus command queue slack, in cycles
    localparam int SETTLE_CYCLES = 3 * (FRAME_WORDS + 4);

    logic        clk;
    logic        rst_n;
    logic        push;
    in_word_t    in_word;
    logic        full;
    logic        empty;
    logic        pop;
    out_word_t   out_word;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    icmp_echo_ping_engine u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .in_word   (in_word),
        .full      (full),
        .empty     (empty),
        .pop       (pop),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow registers, same reset values as the engine
    logic [47:0] sh_own_mac;
    logic [31:0] sh_own_ip;
    logic [47:0] sh_peer_mac;
    logic [31:0] sh_peer_ip;
    logic [15:0] sh_ident;
    logic [15:0] sh_seq;
    logic [31:0] sh_spins;
    logic [7:0]  sh_try_limit;

    // Predicted engine state
    bit          ping_active;
    logic [7:0]  tries_sent;
    logic [31:0] spins_seen;
    int          rx_pos;
    bit          rx_good;
    logic [15:0] ip_sum;
    logic [15:0] icmp_sum;

    out_word_t   pending_words[$];
    int          errors;
    int          cycles;
    int          n_frames;
    int          n_matches;
    int          n_timeouts;
    bit          no_idle;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here
    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench: timeout after %0d cycles", cycles);
            $display("testbench: done, errors");
            $finish;
        end
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
        errors = errors + 1;
    endtask

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic logic [15:0] fold_sum(input logic [31:0] s);
        while (s[31:16] != 16'd0)
            s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
        return ~s[15:0];
    endfunction

    function automatic logic [7:0] payload_at(input int i);
        return 8'(65 + (i % 26));
    endfunction

    // Work out both checksums from the current registers
    task automatic compute_sums();
        logic [31:0] s;
        int i;
        s = 32'h4500 + 32'(28 + PAYLOAD_BYTES) + 32'h0001 + 32'h4001;
        s = s + {16'd0, sh_own_ip[31:16]} + {16'd0, sh_own_ip[15:0]}
              + {16'd0, sh_peer_ip[31:16]} + {16'd0, sh_peer_ip[15:0]};
        ip_sum = fold_sum(s);
        s = 32'h0800 + {16'd0, sh_ident} + {16'd0, sh_seq};
        for (i = 0; i + 1 < PAYLOAD_BYTES; i += 2)
            s = s + {16'd0, payload_at(i), payload_at(i + 1)};
        if (i < PAYLOAD_BYTES)
            s = s + {16'd0, payload_at(i), 8'd0};
        icmp_sum = fold_sum(s);
    endtask

    function automatic logic [7:0] request_byte(input int p);
        if (p < 6)
            return sh_peer_mac[8 * (5 - p) +: 8];
        if (p < 12)
            return sh_own_mac[8 * (11 - p) +: 8];
        if (p >= 26 && p < 30)
            return sh_own_ip[8 * (29 - p) +: 8];
        if (p >= 30 && p < 34)
            return sh_peer_ip[8 * (33 - p) +: 8];
        if (p >= 42 && p < FRAME_LEN)
            return payload_at(p - 42);
        case (p)
            12: return 8'h08;
            14: return 8'h45;
            16: return 8'((28 + PAYLOAD_BYTES) >> 8);
            17: return 8'(28 + PAYLOAD_BYTES);
            19: return 8'd1;
            22: return 8'd64;
            23: return 8'd1;
            24: return ip_sum[15:8];
            25: return ip_sum[7:0];
            34: return 8'd8;
            36: return icmp_sum[15:8];
            37: return icmp_sum[7:0];
            38: return sh_ident[15:8];
            39: return sh_ident[7:0];
            40: return sh_seq[15:8];
            41: return sh_seq[7:0];
            default: return 8'd0;
        endcase
    endfunction

    // Which reply bytes are compared, and against what
    function automatic bit reply_checked(input int p, output logic [7:0] want);
        want = 8'd0;
        if (p == 12 || p == 13 || p == 23 || (p >= 38 && p < FRAME_LEN))
        begin
            want = request_byte(p);
            return 1'b1;
        end
        if (p >= 26 && p < 30)
        begin
            want = sh_peer_ip[8 * (29 - p) +: 8];
            return 1'b1;
        end
        return p == 34;
    endfunction

    task automatic queue_request();
        out_word_t w;
        int k;
        compute_sums();
        for (k = 0; k < FRAME_WORDS; k++)
        begin
            w.kind    = KIND_TX;
            w.tx_word = {request_byte(2 * k),
                         (2 * k + 1 < FRAME_LEN) ? request_byte(2 * k + 1) : 8'd0};
            w.tx_end  = (k == FRAME_WORDS - 1);
            pending_words.push_back(w);
        end
    endtask

    task automatic queue_status(input logic [1:0] kind);
        out_word_t w;
        w.kind    = kind;
        w.tx_word = 16'd0;
        w.tx_end  = 1'b0;
        pending_words.push_back(w);
    endtask

    // Advance the predicted engine by one accepted input word
    task automatic ping_predict(input in_word_t w);
        logic [7:0] want;
        case (w.op)
            OP_START:
            begin
                ping_active = 1'b1;
                tries_sent  = 8'd1;
                spins_seen  = 32'd0;
                rx_pos      = 0;
                rx_good     = 1'b1;
                queue_request();
            end
            OP_RX:
            begin
                if (rx_pos < RX_FRAME_MAX)
                begin
                    if (reply_checked(rx_pos, want) && want != w.rx_data)
                        rx_good = 1'b0;
                    rx_pos = rx_pos + 1;
                end
                if (w.rx_end)
                begin
                    if (ping_active && rx_good && rx_pos >= FRAME_LEN)
                    begin
                        ping_active = 1'b0;
                        queue_status(KIND_MATCH);
                    end
                    rx_pos  = 0;
                    rx_good = 1'b1;
                end
            end
            OP_TICK:
            begin
                if (ping_active)
                begin
                    spins_seen = spins_seen + 32'd1;
                    if (spins_seen >= ((sh_spins == 0) ? 32'd1 : sh_spins))
                    begin
                        spins_seen = 32'd0;
                        if (tries_sent >= ((sh_try_limit == 0) ? 8'd1 : sh_try_limit))
                        begin
                            ping_active = 1'b0;
                            queue_status(KIND_TIMEOUT);
                        end
                        else
                        begin
                            tries_sent = tries_sent + 8'd1;
                            queue_request();
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Send one input word; called and returns at a falling edge
    task automatic send_word(input logic [1:0] op, input logic [7:0] data, input logic last);
        in_word_t w;
        w.op      = op;
        w.rx_data = data;
        w.rx_end  = last;
        push = 1'b0;
        repeat (draw_gap()) @(negedge clk);
        push    = 1'b1;
        in_word = w;
        do
            @(posedge clk);
        while (full);
        ping_predict(w);
        @(negedge clk);
        push = 1'b0;
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [63:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_OWN_MAC:   sh_own_mac   = data[47:0];
            REG_OWN_IP:    sh_own_ip    = data[31:0];
            REG_PEER_MAC:  sh_peer_mac  = data[47:0];
            REG_PEER_IP:   sh_peer_ip   = data[31:0];
            REG_IDENT:     sh_ident     = data[15:0];
            REG_SEQ:       sh_seq       = data[15:0];
            REG_SPINS:     sh_spins     = data[31:0];
            REG_TRY_LIMIT: sh_try_limit = data[7:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Hold until every predicted word has popped, then let the engine settle
    task automatic wait_drained();
        while (pending_words.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Feed one received frame; a corrupt frame breaks at most one compared byte
    task automatic send_reply(input int len, input bit corrupt);
        logic [7:0] b;
        int p;
        int bad_pos;
        bad_pos = ($urandom_range(0, 3) == 0) ? 12 : $urandom_range(38, FRAME_LEN - 1);
        for (p = 0; p < len; p++)
        begin
            if (!reply_checked(p, b))
                b = 8'($urandom);
            if (corrupt && p == bad_pos)
                b = b ^ 8'(1 << $urandom_range(0, 7));
            send_word(OP_RX, b, p == len - 1);
        end
    endtask

    task automatic test_reset_values();
        // One tick per period; the default try limit gives resends, then a timeout
        cfg_write(REG_SPINS, 64'd1);
        send_word(OP_START, 8'h00, 1'b0);
        repeat (20) send_word(OP_TICK, 8'h00, 1'b0);
        wait_drained();
    endtask

    task automatic test_register_extremes();
        cfg_write(REG_OWN_MAC, 64'hFFFF_FFFF_FFFF_FFFF);
        cfg_write(REG_OWN_IP, 64'h0000_0000_FFFF_FFFF);
        cfg_write(REG_PEER_MAC, 64'hFFFF_FFFF_FFFF);
        cfg_write(REG_PEER_IP, 64'hFFFF_FFFF);
        cfg_write(REG_IDENT, 64'hFFFF);
        cfg_write(REG_SEQ, 64'hFFFF);
        cfg_write(REG_SPINS, 64'hFFFF_FFFF);
        cfg_write(REG_TRY_LIMIT, 64'hFF);
        send_word(OP_START, 8'hFF, 1'b1);
        send_word(OP_TICK, 8'hFF, 1'b1);
        send_word(2'd3, 8'hA5, 1'b1);
        // Short frame while active never matches
        send_reply(20, 1'b0);
        // Restart while active, then a good reply
        send_word(OP_START, 8'h00, 1'b0);
        send_reply(FRAME_LEN, 1'b0);
        // Engine now idle: a tick and an unknown op give nothing
        send_word(OP_TICK, 8'h00, 1'b0);
        send_word(2'd3, 8'h00, 1'b0);
        wait_drained();
    endtask

    task automatic test_timeouts();
        // Zero period and zero limit act as one
        cfg_write(REG_SPINS, 64'd0);
        cfg_write(REG_TRY_LIMIT, 64'd0);
        send_word(OP_START, 8'h00, 1'b0);
        send_word(OP_TICK, 8'h00, 1'b0);
        send_word(OP_TICK, 8'h00, 1'b0);
        wait_drained();
        cfg_write(REG_SPINS, 64'd2);
        cfg_write(REG_TRY_LIMIT, 64'd3);
        send_word(OP_START, 8'h00, 1'b0);
        send_word(OP_TICK, 8'h00, 1'b0);
        wait_drained();
        // Change the sequence while pinging; the resend picks it up
        cfg_write(REG_SEQ, 64'h1234);
        repeat (5) send_word(OP_TICK, 8'h00, 1'b0);
        // Short frame never matches
        send_reply(10, 1'b0);
        wait_drained();
    endtask

    task automatic test_random_pings();
        int round;
        int k;
        for (round = 0; round < 4; round++)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            if (round % 2 == 0)
            begin
                cfg_write(REG_OWN_MAC, {$urandom, $urandom});
                cfg_write(REG_OWN_IP, {32'd0, $urandom});
                cfg_write(REG_PEER_MAC, {$urandom, $urandom});
                cfg_write(REG_PEER_IP, {32'd0, $urandom});
                cfg_write(REG_IDENT, 64'($urandom_range(0, 65535)));
                cfg_write(REG_SEQ, 64'($urandom_range(0, 65535)));
                cfg_write(REG_SPINS, 64'($urandom_range(1, 3)));
                cfg_write(REG_TRY_LIMIT, 64'($urandom_range(1, 3)));
            end
            send_word(OP_START, 8'($urandom), 1'($urandom));
            for (k = 0; k < 3; k++)
            begin
                case ($urandom_range(0, 4))
                    0:
                        send_reply($urandom_range(1, 8), $urandom_range(0, 1) == 0);
                    1, 2:
                        send_word(OP_TICK, 8'($urandom), 1'($urandom));
                    3:
                        send_word(2'd3, 8'($urandom), 1'($urandom));
                    default:
                        send_word(OP_START, 8'($urandom), 1'($urandom));
                endcase
            end
            // Run out the ping so each round ends in a timeout
            while (ping_active)
                send_word(OP_TICK, 8'($urandom), 1'($urandom));
            if (round % 2 == 1)
                wait_drained();
        end
        no_idle = 1'b0;
        wait_drained();
    endtask

    // Drive pop with a fresh random stall for every word
    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            pop = 1'b0;
            repeat (draw_gap()) @(negedge clk);
            pop = 1'b1;
            do
                @(posedge clk);
            while (empty);
        end
    end

    // Compare each popped word with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pending_words.size() == 0)
                report("unexpected word", {13'd0, out_word}, 32'd0);
            else
            begin
                if (out_word.kind != pending_words[0].kind)
                    report("kind", 32'(out_word.kind), 32'(pending_words[0].kind));
                if (out_word.tx_word != pending_words[0].tx_word)
                    report("tx_word", 32'(out_word.tx_word), 32'(pending_words[0].tx_word));
                if (out_word.tx_end != pending_words[0].tx_end)
                    report("tx_end", 32'(out_word.tx_end), 32'(pending_words[0].tx_end));
                case (pending_words[0].kind)
                    KIND_MATCH:   n_matches = n_matches + 1;
                    KIND_TIMEOUT: n_timeouts = n_timeouts + 1;
                    default:      n_frames = n_frames + int'(pending_words[0].tx_end);
                endcase
                void'(pending_words.pop_front());
            end
        end
    end

    initial
    begin
        errors       = 0;
        cycles       = 0;
        n_frames     = 0;
        n_matches    = 0;
        n_timeouts   = 0;
        no_idle      = 1'b0;
        rst_n        = 1'b0;
        push         = 1'b0;
        in_word      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_OWN_MAC;
        cfg_data     = 64'd0;
        sh_own_mac   = 48'd0;
        sh_own_ip    = 32'd167772687;
        sh_peer_mac  = 48'd0;
        sh_peer_ip   = 32'd0;
        sh_ident     = 16'd0;
        sh_seq       = 16'd0;
        sh_spins     = 32'd2000000;
        sh_try_limit = 8'd20;
        ping_active  = 1'b0;
        tries_sent   = 8'd0;
        spins_seen   = 32'd0;
        rx_pos       = 0;
        rx_good      = 1'b1;
        ip_sum       = 16'd0;
        icmp_sum     = 16'd0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_values();
        test_register_extremes();
        test_timeouts();
        test_random_pings();

        if (pending_words.size() != 0)
            report("words never popped", 32'(pending_words.size()), 32'd0);
        $display("testbench: %0d request frames, %0d reply matches, %0d timeouts checked",
                 n_frames, n_matches, n_timeouts);
        $display("testbench: register extremes, restarts, idle traffic and short frames run");
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule
